[hw/rtl/mbrp_pkg.sv]
// ----------------------------------------------------------------------------
// mbrp_pkg - Modbus RTU read poll sequencer package
// Shared codes, constants, job descriptor and request/CRC helpers.
// ----------------------------------------------------------------------------
package mbrp_pkg;

  // reply bytes captured per read
  localparam int          BLOCK_BYTES = 90;
  localparam logic [8:0]  WIN_LO      = 9'd3;
  localparam logic [8:0]  WIN_HI      = 9'(3 + BLOCK_BYTES);

  localparam logic [7:0]  REG_COUNT   = 8'h2D;
  localparam logic [7:0]  FUNC_HOLD   = 8'h03;
  localparam logic [7:0]  FUNC_INPUT  = 8'h04;
  localparam logic [7:0]  ADDR_BLK0   = 8'h00;
  localparam logic [7:0]  ADDR_BLK1   = 8'h2D;
  localparam logic [7:0]  ADDR_BLK2   = 8'h54;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;

  localparam logic [8:0]  HOLD_FULL   = 9'd270;
  localparam logic [7:0]  INP_FULL    = 8'd180;
  localparam logic [8:0]  HOLD_MAX    = 9'h1FF;
  localparam logic [7:0]  INP_MAX     = 8'hFF;
  localparam logic [7:0]  POS_MAX     = 8'hFF;

  localparam logic [7:0]  ADDR_RESET  = 8'd1;

  localparam logic [2:0]  FIRST_INPUT_PHASE = 3'd3;
  localparam logic [2:0]  LAST_PHASE        = 3'd4;

  // request frame byte slots
  localparam logic [2:0]  SLOT_ADDR   = 3'd0;
  localparam logic [2:0]  SLOT_FUNC   = 3'd1;
  localparam logic [2:0]  SLOT_STH    = 3'd2;
  localparam logic [2:0]  SLOT_STL    = 3'd3;
  localparam logic [2:0]  SLOT_CNTH   = 3'd4;
  localparam logic [2:0]  SLOT_CNTL   = 3'd5;
  localparam logic [2:0]  SLOT_CRCL   = 3'd6;
  localparam logic [2:0]  SLOT_CRCH   = 3'd7;

  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_BYTE    = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_IMG  = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef struct packed {
    logic       load;
    logic       req;
    logic [2:0] phase;
    kind_t      kind;
    logic [7:0] value;
    logic       bank;
    logic [8:0] idx;
    logic       done;
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] plan_func(input logic [2:0] phase);
    logic [7:0] f;
    case (phase)
      3'd0, 3'd1, 3'd2: f = FUNC_HOLD;
      default:          f = FUNC_INPUT;
    endcase
    return f;
  endfunction

  function automatic logic [7:0] plan_addr(input logic [2:0] phase);
    logic [7:0] a;
    case (phase)
      3'd0:    a = ADDR_BLK0;
      3'd1:    a = ADDR_BLK1;
      3'd2:    a = ADDR_BLK2;
      3'd3:    a = ADDR_BLK0;
      default: a = ADDR_BLK1;
    endcase
    return a;
  endfunction

endpackage

[hw/rtl/mbrp_out.sv]
// ----------------------------------------------------------------------------
// mbrp_out - result stage
// Holds one job: a single result word, or an 8-byte request frame that it
// streams out one word per cycle while out_tready is high, building the CRC as bytes leave.
// ----------------------------------------------------------------------------
module mbrp_out (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mbrp_pkg::job_t       job,
  input  logic [7:0]           slave_address,
  output logic                 slot_free,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [7:0] byte_value, [8] bank, [17:9] byte_index, [18] image_complete, rest 0
  output logic [23:0]          out_tdata,
  // [1:0] kind
  output logic [1:0]           out_tuser,
  output logic                 out_tlast
);

  logic                vld_r,   vld_nxt;
  logic                req_r,   req_nxt;
  logic [2:0]          cnt_r,   cnt_nxt;
  logic [2:0]          phase_r, phase_nxt;
  mbrp_pkg::kind_t     kind_r,  kind_nxt;
  logic [7:0]          value_r, value_nxt;
  logic                bank_r,  bank_nxt;
  logic [8:0]          idx_r,   idx_nxt;
  logic                done_r,  done_nxt;
  logic [15:0]         crc_r,   crc_nxt;

  logic       fire;
  logic       finish;
  logic       frame_end;
  logic [7:0] tx_byte;

  assign frame_end = cnt_r == mbrp_pkg::SLOT_CRCH;
  assign fire      = vld_r & out_tready;
  assign finish    = fire & (~req_r | frame_end);
  assign slot_free = ~vld_r | finish;

  always_comb begin
    case (cnt_r)
      mbrp_pkg::SLOT_ADDR: tx_byte = slave_address;
      mbrp_pkg::SLOT_FUNC: tx_byte = mbrp_pkg::plan_func(phase_r);
      mbrp_pkg::SLOT_STH:  tx_byte = 8'h00;
      mbrp_pkg::SLOT_STL:  tx_byte = mbrp_pkg::plan_addr(phase_r);
      mbrp_pkg::SLOT_CNTH: tx_byte = 8'h00;
      mbrp_pkg::SLOT_CNTL: tx_byte = mbrp_pkg::REG_COUNT;
      mbrp_pkg::SLOT_CRCL: tx_byte = crc_r[7:0];
      default:             tx_byte = crc_r[15:8];
    endcase
  end

  always_comb begin
    vld_nxt   = vld_r;
    req_nxt   = req_r;
    cnt_nxt   = cnt_r;
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    value_nxt = value_r;
    bank_nxt  = bank_r;
    idx_nxt   = idx_r;
    done_nxt  = done_r;
    crc_nxt   = crc_r;
    if (fire) begin
      // header bytes feed the CRC as they go out
      if (req_r && cnt_r < mbrp_pkg::SLOT_CRCL) begin
        crc_nxt = mbrp_pkg::crc_byte(crc_r, tx_byte);
      end
      cnt_nxt = cnt_r + 3'd1;
      if (finish) begin
        vld_nxt = 1'b0;
      end
    end
    if (job.load) begin
      vld_nxt   = 1'b1;
      req_nxt   = job.req;
      cnt_nxt   = mbrp_pkg::SLOT_ADDR;
      crc_nxt   = mbrp_pkg::CRC_INIT;
      phase_nxt = job.phase;
      kind_nxt  = job.kind;
      value_nxt = job.value;
      bank_nxt  = job.bank;
      idx_nxt   = job.idx;
      done_nxt  = job.done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r   <= req_nxt;
    cnt_r   <= cnt_nxt;
    phase_r <= phase_nxt;
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    bank_r  <= bank_nxt;
    idx_r   <= idx_nxt;
    done_r  <= done_nxt;
    crc_r   <= crc_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = req_r ? mbrp_pkg::KIND_TX : kind_r;
  assign out_tlast  = ~req_r | frame_end;
  assign out_tdata  = req_r ? {16'h0000, tx_byte}
                            : {5'b00000, done_r, idx_r, bank_r, value_r};

endmodule

[hw/rtl/modbus_rtu_read_poll_sequencer.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_read_poll_sequencer - Modbus RTU master read poll sequencer
// Five-read poll plan, request framing with CRC-16, reply byte capture.
// ----------------------------------------------------------------------------
// The first result word is registered: it appears in the cycle after the input
// word is accepted. One output word per cycle while out_tready is high; a request
// frame is eight words, a byte word gives at most one. A new input word is taken
// in the cycle the result stage empties, so single-result words keep that rate.
// Reset (rst_n low, synchronous): idle, phase 0, counts cleared, address 1.
module modbus_rtu_read_poll_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] rx_byte
  input  logic [7:0]  in_tdata,
  // [1:0] command
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] byte_value, [8] bank, [17:9] byte_index, [18] image_complete, rest 0
  output logic [23:0] out_tdata,
  // [1:0] kind
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  logic [7:0] addr_r;
  logic       busy_r,  busy_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [7:0] pos_r,   pos_nxt;
  logic [8:0] hcnt_r,  hcnt_nxt;
  logic [7:0] icnt_r,  icnt_nxt;

  logic           slot_free;
  logic           accept;
  logic           in_win;
  mbrp_pkg::cmd_t cmd;
  mbrp_pkg::job_t job;

  assign in_tready = slot_free;
  assign accept    = in_tvalid & slot_free;
  assign cmd       = mbrp_pkg::cmd_t'(in_tuser);
  assign in_win    = ({1'b0, pos_r} >= mbrp_pkg::WIN_LO) && ({1'b0, pos_r} < mbrp_pkg::WIN_HI);

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    hcnt_nxt  = hcnt_r;
    icnt_nxt  = icnt_r;
    job       = '0;
    job.kind  = mbrp_pkg::KIND_TX;
    if (accept) begin
      case (cmd)
        mbrp_pkg::CMD_START: begin
          if (!busy_r) begin
            busy_nxt  = 1'b1;
            phase_nxt = 3'd0;
            pos_nxt   = 8'd0;
            hcnt_nxt  = 9'd0;
            icnt_nxt  = 8'd0;
            job.load  = 1'b1;
            job.req   = 1'b1;
            job.phase = 3'd0;
          end
        end
        mbrp_pkg::CMD_BYTE: begin
          if (busy_r) begin
            if (pos_r < mbrp_pkg::POS_MAX) begin
              pos_nxt = pos_r + 8'd1;
            end
            if (in_win) begin
              job.load  = 1'b1;
              job.kind  = mbrp_pkg::KIND_IMG;
              job.value = in_tdata;
              if (phase_r < mbrp_pkg::FIRST_INPUT_PHASE) begin
                job.bank = 1'b0;
                job.idx  = hcnt_r;
                if (hcnt_r < mbrp_pkg::HOLD_MAX) begin
                  hcnt_nxt = hcnt_r + 9'd1;
                end
              end else begin
                job.bank = 1'b1;
                job.idx  = {1'b0, icnt_r};
                if (icnt_r < mbrp_pkg::INP_MAX) begin
                  icnt_nxt = icnt_r + 8'd1;
                end
              end
            end
          end
        end
        mbrp_pkg::CMD_TIMEOUT: begin
          if (busy_r) begin
            pos_nxt = 8'd0;
            if (phase_r < mbrp_pkg::LAST_PHASE) begin
              phase_nxt = phase_r + 3'd1;
              job.load  = 1'b1;
              job.req   = 1'b1;
              job.phase = phase_r + 3'd1;
            end else begin
              busy_nxt  = 1'b0;
              phase_nxt = 3'd0;
              job.load  = 1'b1;
              job.kind  = mbrp_pkg::KIND_DONE;
              job.done  = (hcnt_r == mbrp_pkg::HOLD_FULL) && (icnt_r == mbrp_pkg::INP_FULL);
            end
          end
        end
        default: begin
          // unused command code: no effect
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= mbrp_pkg::ADDR_RESET;
    end else if (cfg_we) begin
      addr_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 3'd0;
      pos_r   <= 8'd0;
      hcnt_r  <= 9'd0;
      icnt_r  <= 8'd0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      hcnt_r  <= hcnt_nxt;
      icnt_r  <= icnt_nxt;
    end
  end

  mbrp_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .job           (job),
    .slave_address (addr_r),
    .slot_free     (slot_free),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast)
  );

endmodule

[tb/sv/modbus_rtu_read_poll_sequencer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modbus_rtu_read_poll_sequencer_tb - self-checking bench for the poll sequencer
// A directed table covers idle drops, request framing and the capture window.
// Random poll traffic follows under changing backpressure and slave addresses.
// Every result word is checked field by field against its table row or an in-bench
// predictor of the poll plan.
// ----------------------------------------------------------------------------
module modbus_rtu_read_poll_sequencer_tb;

  localparam logic [1:0] CMD_RSVD      = 2'd3;  // unused command code, dropped
  localparam int         STALL_LIMIT   = 2000;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         SETTLE_CYCLES = 12;
  localparam int         READS         = 5;

  typedef enum logic [1:0] {
    ROW_MODEL,  // expectation from the predictor
    ROW_QUIET,  // no result word
    ROW_ONE     // one typed result word
  } row_mode_t;

  typedef struct packed {
    mbrp_pkg::kind_t kind;
    logic [7:0]      value;
    logic            bank;
    logic [8:0]      idx;
    logic            done;
    logic            last;
  } poll_res_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    row_mode_t  mode;
    poll_res_t  res;
  } poll_row_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [7:0]  cfg_wdata  = 8'h00;
  logic        in_tvalid  = 1'b0;
  logic [7:0]  in_tdata   = 8'h00;
  logic [1:0]  in_tuser   = 2'd0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  modbus_rtu_read_poll_sequencer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  m_addr  = mbrp_pkg::ADDR_RESET;
  logic        m_busy  = 1'b0;
  logic [2:0]  m_phase = 3'd0;
  logic [7:0]  m_pos   = 8'd0;
  logic [8:0]  m_hold  = 9'd0;
  logic [7:0]  m_inp   = 8'd0;
  logic [15:0] m_crc   = mbrp_pkg::CRC_INIT;

  logic [7:0] read_fc    [READS] = '{mbrp_pkg::FUNC_HOLD, mbrp_pkg::FUNC_HOLD,
                                     mbrp_pkg::FUNC_HOLD, mbrp_pkg::FUNC_INPUT,
                                     mbrp_pkg::FUNC_INPUT};
  logic [7:0] read_start [READS] = '{mbrp_pkg::ADDR_BLK0, mbrp_pkg::ADDR_BLK1,
                                     mbrp_pkg::ADDR_BLK2, mbrp_pkg::ADDR_BLK0,
                                     mbrp_pkg::ADDR_BLK1};

  poll_res_t pend_q[$];   // words caused by the last input word
  poll_res_t exp_q[$];    // words still owed by the block

  int errors       = 0;
  int live_items   = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int hold_token   = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int idle_run     = 0;

  function automatic poll_res_t mk_res(mbrp_pkg::kind_t k, logic [7:0] v, logic bk,
                                       logic [8:0] ix, logic dn, logic lst);
    poll_res_t r;
    r.kind  = k;
    r.value = v;
    r.bank  = bk;
    r.idx   = ix;
    r.done  = dn;
    r.last  = lst;
    return r;
  endfunction

  function automatic poll_row_t mk_row(logic [1:0] cmd, logic [7:0] data, row_mode_t mode,
                                       poll_res_t res);
    poll_row_t w;
    w.cmd  = cmd;
    w.data = data;
    w.mode = mode;
    w.res  = res;
    return w;
  endfunction

  function automatic poll_row_t model_row(logic [1:0] cmd, logic [7:0] data);
    return mk_row(cmd, data, ROW_MODEL, '0);
  endfunction

  function automatic logic [15:0] crc16_update(logic [15:0] c, logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      x = x[0] ? ((x >> 1) ^ mbrp_pkg::CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

  function automatic void push_request(logic [2:0] p);
    logic [7:0] frame [8];
    logic [2:0] r;
    r = (p > mbrp_pkg::LAST_PHASE) ? mbrp_pkg::LAST_PHASE : p;
    frame[0] = m_addr;
    frame[1] = read_fc[r];
    frame[2] = 8'h00;
    frame[3] = read_start[r];
    frame[4] = 8'h00;
    frame[5] = mbrp_pkg::REG_COUNT;
    m_crc = mbrp_pkg::CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      m_crc = crc16_update(m_crc, frame[i]);
    end
    frame[6] = m_crc[7:0];
    frame[7] = m_crc[15:8];
    for (int i = 0; i < 8; i++) begin
      pend_q.push_back(mk_res(mbrp_pkg::KIND_TX, frame[i], 1'b0, 9'd0, 1'b0, i == 7));
    end
  endfunction

  // advances the poll state by one word; returns 0 when the word is dropped
  function automatic bit poll_model(logic [1:0] cmd, logic [7:0] b);
    logic [7:0] pos;
    pend_q.delete();
    if (cmd == mbrp_pkg::CMD_START) begin
      if (m_busy) return 1'b0;
      m_busy  = 1'b1;
      m_phase = 3'd0;
      m_pos   = 8'd0;
      m_hold  = 9'd0;
      m_inp   = 8'd0;
      push_request(3'd0);
      return 1'b1;
    end
    if (!m_busy || cmd == CMD_RSVD) return 1'b0;
    if (cmd == mbrp_pkg::CMD_BYTE) begin
      pos = m_pos;
      if (m_pos != mbrp_pkg::POS_MAX) m_pos = m_pos + 8'd1;
      if (pos >= mbrp_pkg::WIN_LO && pos < mbrp_pkg::WIN_HI) begin
        if (m_phase < mbrp_pkg::FIRST_INPUT_PHASE) begin
          pend_q.push_back(mk_res(mbrp_pkg::KIND_IMG, b, 1'b0, m_hold, 1'b0, 1'b1));
          if (m_hold != mbrp_pkg::HOLD_MAX) m_hold = m_hold + 9'd1;
        end else begin
          pend_q.push_back(mk_res(mbrp_pkg::KIND_IMG, b, 1'b1, {1'b0, m_inp}, 1'b0, 1'b1));
          if (m_inp != mbrp_pkg::INP_MAX) m_inp = m_inp + 8'd1;
        end
      end
      return 1'b1;
    end
    // silence timeout closes the reply
    m_pos = 8'd0;
    if (m_phase < mbrp_pkg::LAST_PHASE) begin
      m_phase = m_phase + 3'd1;
      push_request(m_phase);
    end else begin
      m_busy  = 1'b0;
      m_phase = 3'd0;
      pend_q.push_back(mk_res(mbrp_pkg::KIND_DONE, 8'h00, 1'b0, 9'd0,
                              m_hold == mbrp_pkg::HOLD_FULL && m_inp == mbrp_pkg::INP_FULL,
                              1'b1));
    end
    return 1'b1;
  endfunction

  task automatic send_word(input poll_row_t w);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= w.cmd;
    in_tdata  <= w.data;
    do @(posedge clk); while (!in_tready);
    if (poll_model(w.cmd, w.data)) live_items++;
    case (w.mode)
      ROW_MODEL: foreach (pend_q[i]) exp_q.push_back(pend_q[i]);
      ROW_ONE:   exp_q.push_back(w.res);
      default:   ;
    endcase
  endtask

  // replies are mostly short; now and then one nears or runs past the window's end
  task automatic run_poll();
    int len;
    send_word(model_row(mbrp_pkg::CMD_START, 8'($urandom)));
    for (int r = 0; r < READS; r++) begin
      if ($urandom_range(19) == 0) begin
        len = $urandom_range(mbrp_pkg::BLOCK_BYTES, mbrp_pkg::BLOCK_BYTES + 10);
      end else begin
        len = $urandom_range(0, 8);
      end
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(39) == 0) begin
          send_word(model_row(2'($urandom), 8'($urandom)));
        end
        send_word(model_row(mbrp_pkg::CMD_BYTE, 8'($urandom)));
      end
      send_word(model_row(mbrp_pkg::CMD_TIMEOUT, 8'($urandom)));
    end
  endtask

  task automatic random_phase(input int n);
    int stop_at;
    stop_at = live_items + n;
    while (live_items < stop_at) begin
      if ($urandom_range(99) < 80) run_poll();
      else repeat ($urandom_range(1, 6)) send_word(model_row(2'($urandom), 8'($urandom)));
    end
    // leave the sequencer idle
    while (m_busy) send_word(model_row(mbrp_pkg::CMD_TIMEOUT, 8'($urandom)));
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (exp_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_addr(input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    m_addr = v;
  endtask

  task automatic check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_seen != hold_token) begin
      hold_seen  <= hold_token;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    poll_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_q.size() == 0) begin
        $display("%0t: unexpected word kind %0d data %h last %b", $time, out_tuser,
                 out_tdata, out_tlast);
        errors++;
      end else begin
        want = exp_q.pop_front();
        check_field("kind", 9'(want.kind), 9'(out_tuser));
        check_field("byte_value", 9'(want.value), 9'(out_tdata[7:0]));
        check_field("bank", 9'(want.bank), 9'(out_tdata[8]));
        check_field("byte_index", want.idx, out_tdata[17:9]);
        check_field("image_complete", 9'(want.done), 9'(out_tdata[18]));
        check_field("pad", 9'd0, 9'(out_tdata[23:19]));
        check_field("last", 9'(want.last), 9'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_run <= 0;
    end else if (idle_run == STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d words owed", $time, STALL_LIMIT,
               exp_q.size());
      $display("FAILURE");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    poll_row_t tab[$];
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle drops, first poll with short replies, capture window edges
    tab.push_back(mk_row(mbrp_pkg::CMD_BYTE,    8'h5A, ROW_QUIET, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_TIMEOUT, 8'h00, ROW_QUIET, '0));
    tab.push_back(mk_row(CMD_RSVD,              8'hFF, ROW_QUIET, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_START,   8'h00, ROW_MODEL, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_START,   8'hFF, ROW_QUIET, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_BYTE,    8'h01, ROW_QUIET, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_BYTE,    8'h03, ROW_QUIET, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_BYTE,    8'hB4, ROW_QUIET, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_BYTE,    8'h00, ROW_ONE,
                         mk_res(mbrp_pkg::KIND_IMG, 8'h00, 1'b0, 9'd0, 1'b0, 1'b1)));
    tab.push_back(mk_row(mbrp_pkg::CMD_BYTE,    8'hFF, ROW_ONE,
                         mk_res(mbrp_pkg::KIND_IMG, 8'hFF, 1'b0, 9'd1, 1'b0, 1'b1)));
    tab.push_back(mk_row(CMD_RSVD,              8'h00, ROW_QUIET, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_TIMEOUT, 8'hFF, ROW_MODEL, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_BYTE,    8'h80, ROW_QUIET, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_BYTE,    8'h7F, ROW_QUIET, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_BYTE,    8'h55, ROW_QUIET, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_BYTE,    8'hAA, ROW_ONE,
                         mk_res(mbrp_pkg::KIND_IMG, 8'hAA, 1'b0, 9'd2, 1'b0, 1'b1)));
    tab.push_back(mk_row(mbrp_pkg::CMD_TIMEOUT, 8'h00, ROW_MODEL, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_TIMEOUT, 8'h00, ROW_MODEL, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_BYTE,    8'h11, ROW_QUIET, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_BYTE,    8'h22, ROW_QUIET, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_BYTE,    8'h33, ROW_QUIET, '0));
    tab.push_back(mk_row(mbrp_pkg::CMD_BYTE,    8'hA5, ROW_ONE,
                         mk_res(mbrp_pkg::KIND_IMG, 8'hA5, 1'b1, 9'd0, 1'b0, 1'b1)));
    tab.push_back(mk_row(mbrp_pkg::CMD_TIMEOUT, 8'h00, ROW_MODEL, '0));
    // short image, so completion without the complete flag
    tab.push_back(mk_row(mbrp_pkg::CMD_TIMEOUT, 8'h00, ROW_ONE,
                         mk_res(mbrp_pkg::KIND_DONE, 8'h00, 1'b0, 9'd0, 1'b0, 1'b1)));
    tab.push_back(mk_row(mbrp_pkg::CMD_TIMEOUT, 8'hC3, ROW_QUIET, '0));
    foreach (tab[i]) send_word(tab[i]);

    quiesce();
    write_addr(8'h00);
    snd_idle_pct = 8;
    rcv_idle_pct = 82;
    random_phase(110);

    quiesce();
    write_addr(8'hFF);
    snd_idle_pct = 82;
    rcv_idle_pct = 8;
    random_phase(110);

    quiesce();
    write_addr(8'($urandom));
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    hold_token = hold_token + 1;   // output held off while words keep coming
    random_phase(110);

    quiesce();
    if (errors == 0 && exp_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
